FILE: rtl/ppau_pkg.sv
// Package for the packed pixel access unit: register indexes, reset values,
// status codes, controller states and controller/datapath command structs.
// No dependencies.
package ppau_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 15;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_STRIDE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_SIZE_MODE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_DEPTH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT          = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_BYTE_FIRST = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_OFFSET      = 3'd5;

  localparam logic [14:0] RST_ROW_STRIDE = 15'd4;
  localparam logic [1:0]  RST_MODE       = 2'd3;
  localparam logic [5:0]  RST_DEPTH      = 6'd32;
  localparam logic [1:0]  RST_LAYOUT     = 2'd0;

  localparam logic [1:0] MODE_1BPP  = 2'd0;
  localparam logic [1:0] MODE_32BPP = 2'd3;

  localparam logic [1:0] LAYOUT_Z    = 2'd0;
  localparam logic [1:0] LAYOUT_RGBA = 2'd1;

  localparam logic REQ_WRITE = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNSUP = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_ADDR,
    S_DISPATCH,
    S_READ,
    S_DRAIN,
    S_MODIFY,
    S_WRITE,
    S_FIN
  } ppau_state_e;

  typedef struct packed {
    logic load_req;
    logic calc_mul;
    logic calc_addr;
    logic rd_issue;
    logic wr_byte;
    logic wr_bit;
    logic load_out;
  } ppau_cmd_t;

  typedef struct packed {
    logic err;
    logic is_write;
    logic bit_mode;
    logic last_byte;
    logic out_busy;
  } ppau_sts_t;

  function automatic logic [31:0] depth_mask(input logic [5:0] depth);
    logic [31:0] m;
    if (depth >= 6'd32) begin
      m = 32'hffffffff;
    end else begin
      m = (32'd1 << depth[4:0]) - 32'd1;
    end
    return m;
  endfunction

endpackage

FILE: rtl/ppau_req_if.sv
// Request channel of the packed pixel access unit: valid/ready plus payload.
// No dependencies.
interface ppau_req_if #(
  parameter int unsigned COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic                  req_type;
  logic [COORD_BITS-1:0] x_pos;
  logic [COORD_BITS-1:0] y_pos;
  logic [31:0]           pixel_value;

  modport source (output valid, req_type, x_pos, y_pos, pixel_value, input ready);
  modport sink   (input valid, req_type, x_pos, y_pos, pixel_value, output ready);
endinterface

FILE: rtl/ppau_rsp_if.sv
// Result channel of the packed pixel access unit: valid/ready plus payload.
// No dependencies.
interface ppau_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_value;
  logic [1:0]  status;

  modport source (output valid, read_value, status, input ready);
  modport sink   (input valid, read_value, status, output ready);
endinterface

FILE: rtl/ppau_ctrl.sv
// Controller of the packed pixel access unit: sequences address calculation,
// byte reads and writes and result hand-off. Depends on ppau_pkg.
module ppau_ctrl
  import ppau_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ppau_sts_t sts_i,
  output ppau_cmd_t cmd_o
);

  ppau_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.calc_mul = 1'b1;
        state_d        = S_ADDR;
      end
      S_ADDR: begin
        cmd_o.calc_addr = 1'b1;
        state_d         = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (sts_i.err) begin
          state_d = S_FIN;
        end else if (sts_i.is_write && !sts_i.bit_mode) begin
          state_d = S_WRITE;
        end else begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd_issue = 1'b1;
        if (sts_i.last_byte) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = sts_i.is_write ? S_MODIFY : S_FIN;
      end
      S_MODIFY: begin
        cmd_o.wr_bit = 1'b1;
        state_d      = S_FIN;
      end
      S_WRITE: begin
        cmd_o.wr_byte = 1'b1;
        if (sts_i.last_byte) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/ppau_dp.sv
// Datapath of the packed pixel access unit: config registers, address
// multiply/add, range check, byte-wide image store and result register.
// Depends on ppau_pkg.
module ppau_dp
  import ppau_pkg::*;
#(
  parameter int unsigned STORE_BYTES = 65536,
  parameter int unsigned COORD_BITS  = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  req_type_i,
  input  logic [COORD_BITS-1:0] x_pos_i,
  input  logic [COORD_BITS-1:0] y_pos_i,
  input  logic [31:0]           pixel_value_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [31:0]           read_value_o,
  output logic [1:0]            status_o,
  input  ppau_cmd_t             cmd_i,
  output ppau_sts_t             sts_o
);

  localparam int unsigned MW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int unsigned PW = COORD_BITS + 15;
  localparam int unsigned XW = COORD_BITS + 2;
  localparam int unsigned AW = (COORD_BITS + 17 > MW + 1) ? COORD_BITS + 17 : MW + 1;

  // configuration
  logic [14:0] stride_q;
  logic [1:0]  mode_q;
  logic [5:0]  depth_q;
  logic [1:0]  layout_q;
  logic        hbf_q;
  logic [2:0]  bo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_q <= RST_ROW_STRIDE;
      mode_q   <= RST_MODE;
      depth_q  <= RST_DEPTH;
      layout_q <= RST_LAYOUT;
      hbf_q    <= 1'b0;
      bo_q     <= 3'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROW_STRIDE:      stride_q <= cfg_data_i[14:0];
        CFG_PIXEL_SIZE_MODE: mode_q   <= cfg_data_i[1:0];
        CFG_PIXEL_DEPTH:     depth_q  <= cfg_data_i[5:0];
        CFG_LAYOUT:          layout_q <= cfg_data_i[1:0];
        CFG_HIGH_BYTE_FIRST: hbf_q    <= cfg_data_i[0];
        CFG_BIT_OFFSET:      bo_q     <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // request capture
  logic                  wr_q;
  logic [COORD_BITS-1:0] x_q, y_q;
  logic [31:0]           pv_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      wr_q <= (req_type_i == REQ_WRITE);
      x_q  <= x_pos_i;
      y_q  <= y_pos_i;
      pv_q <= pixel_value_i;
    end
  end

  // format decode and multiply
  logic                  bitm_d, zfmt_d, rgba_d, unsup_d;
  logic [1:0]            lg_d;
  logic [COORD_BITS:0]   xo_d;
  logic [XW-1:0]         xoff_d;
  logic [PW-1:0]         prod_q;
  logic [XW-1:0]         xoff_q;
  logic                  bitm_q, unsup_q, masked_q;
  logic [1:0]            lg_q;
  logic [2:0]            bidx_q;

  always_comb begin
    bitm_d  = (mode_q == MODE_1BPP) && (depth_q <= 6'd1);
    zfmt_d  = (layout_q == LAYOUT_Z) && (mode_q != MODE_1BPP);
    rgba_d  = (layout_q == LAYOUT_RGBA) && (mode_q == MODE_32BPP);
    unsup_d = !bitm_d && !zfmt_d && !rgba_d;
    lg_d    = bitm_d ? 2'd0 : 2'(mode_q - 2'd1);
    xo_d    = (COORD_BITS+1)'(x_q) + (COORD_BITS+1)'(bo_q);
    xoff_d  = bitm_d ? XW'(xo_d >> 3) : (XW'(x_q) << lg_d);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_mul) begin
      prod_q   <= PW'(y_q) * PW'(stride_q);
      xoff_q   <= xoff_d;
      bitm_q   <= bitm_d;
      unsup_q  <= unsup_d;
      masked_q <= zfmt_d;
      lg_q     <= lg_d;
      bidx_q   <= xo_d[2:0];
    end
  end

  // address and range check
  logic [AW-1:0] sum_d, limit_d, addr_q;
  logic [1:0]    nbm1;
  logic [1:0]    st_d, st_q;

  always_comb begin
    nbm1    = 2'((3'd1 << lg_q) - 3'd1);
    sum_d   = AW'(prod_q) + AW'(xoff_q);
    limit_d = AW'(STORE_BYTES) - AW'(nbm1) - AW'(1);
    if (unsup_q) begin
      st_d = ST_UNSUP;
    end else if (sum_d > limit_d) begin
      st_d = ST_RANGE;
    end else begin
      st_d = ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_addr) begin
      addr_q <= sum_d;
      st_q   <= st_d;
    end
  end

  // byte sequencing
  logic [1:0]    cnt_q;
  logic          pend_q;
  logic [1:0]    pidx_q;
  logic [31:0]   acc_q;
  logic [7:0]    rdata_q;
  logic [1:0]    wpos, off;
  logic [7:0]    bmask, bit_byte, wdata;
  logic [MW-1:0] mem_idx;
  logic          mem_we;
  logic [7:0]    mem_q [STORE_BYTES];

  always_comb begin
    wpos     = hbf_q ? 2'(nbm1 - cnt_q) : cnt_q;
    off      = cmd_i.wr_byte ? wpos : (cmd_i.wr_bit ? 2'd0 : cnt_q);
    mem_idx  = addr_q[MW-1:0] + MW'(off);
    mem_we   = cmd_i.wr_byte | cmd_i.wr_bit;
    bmask    = 8'd1 << bidx_q;
    bit_byte = pv_q[0] ? (acc_q[7:0] | bmask) : (acc_q[7:0] & ~bmask);
    wdata    = cmd_i.wr_bit ? bit_byte : pv_q[{cnt_q, 3'b000} +: 8];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_idx] <= wdata;
    end
    rdata_q <= mem_q[mem_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 2'd0;
      pend_q <= 1'b0;
    end else begin
      pend_q <= cmd_i.rd_issue;
      if (cmd_i.calc_addr) begin
        cnt_q <= 2'd0;
      end else if (cmd_i.rd_issue || cmd_i.wr_byte) begin
        cnt_q <= cnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q <= cnt_q;
    if (cmd_i.calc_addr) begin
      acc_q <= '0;
    end else if (pend_q) begin
      acc_q[{pidx_q, 3'b000} +: 8] <= rdata_q;
    end
  end

  // result register
  logic        out_valid_q;
  logic [31:0] rv_d, out_rv_q;
  logic [1:0]  out_st_q;

  always_comb begin
    if (st_q != ST_OK || wr_q) begin
      rv_d = '0;
    end else if (bitm_q) begin
      rv_d = {31'd0, acc_q[{2'd0, bidx_q}]};
    end else if (masked_q) begin
      rv_d = acc_q & depth_mask(depth_q);
    end else begin
      rv_d = acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_rv_q <= rv_d;
      out_st_q <= st_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_rv_q;
  assign status_o     = out_st_q;

  always_comb begin
    sts_o.err       = (st_q != ST_OK);
    sts_o.is_write  = wr_q;
    sts_o.bit_mode  = bitm_q;
    sts_o.last_byte = (cnt_q == nbm1);
    sts_o.out_busy  = out_valid_q && !out_ready_i;
  end

endmodule

FILE: rtl/packed_pixel_access_unit.sv
// Top level of the packed pixel access unit: controller plus datapath.
// Depends on ppau_pkg, ppau_req_if, ppau_rsp_if, ppau_ctrl, ppau_dp.
//
//   port   | dir | payload                                  | handshake
//   req    | in  | req_type, x_pos, y_pos, pixel_value      | valid/ready
//   rsp    | out | read_value, status                       | valid/ready
//   cfg    | in  | cfg_idx_i, cfg_data_i                    | cfg_we_i
//
// One item at a time. After address calculation an error goes to the result; an
// N-byte write or read moves its bytes one at a time over the single byte port
// of the image store, and a 1 bpp write reads, then writes back, one byte.
// The result sits in an output register, so the next item is taken while it
// waits; that item holds in its last state until the register frees up.
// Reset clears control and config only; the store holds no reset value.
module packed_pixel_access_unit
  import ppau_pkg::*;
#(
  parameter int unsigned STORE_BYTES = 65536,
  parameter int unsigned COORD_BITS  = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  ppau_req_if.sink              req,
  ppau_rsp_if.source            rsp
);

  ppau_cmd_t cmd;
  ppau_sts_t sts;
  logic      in_ready;

  assign req.ready = in_ready;

  ppau_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ppau_dp #(
    .STORE_BYTES (STORE_BYTES),
    .COORD_BITS  (COORD_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .req_type_i    (req.req_type),
    .x_pos_i       (req.x_pos),
    .y_pos_i       (req.y_pos),
    .pixel_value_i (req.pixel_value),
    .out_valid_o   (rsp.valid),
    .out_ready_i   (rsp.ready),
    .read_value_o  (rsp.read_value),
    .status_o      (rsp.status),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule

FILE: sim/packed_pixel_access_unit_tb.sv
// Testbench for packed_pixel_access_unit: directed and random pixel reads and
// writes over all pixel sizes, layouts and byte orders, each result checked
// against a byte-level image store kept in a scoreboard class.
// Depends on ppau_pkg, ppau_req_if, ppau_rsp_if and the unit's RTL.
import ppau_pkg::*;

localparam int unsigned STORE_BYTES  = 65536;
localparam int unsigned FILL_BYTES   = 1024;
localparam int unsigned DRAIN_CYCLES = 12;
localparam int unsigned CYCLE_LIMIT  = 200000;

localparam logic       REQ_READ     = 1'b0;
localparam logic [1:0] MODE_8BPP    = 2'd1;
localparam logic [1:0] MODE_16BPP   = 2'd2;
localparam logic [1:0] LAYOUT_PLANE = 2'd2;
localparam logic [1:0] LAYOUT_SPARE = 2'd3;

typedef enum int {ACC_BIT, ACC_BYTES, ACC_UNSUP} access_e;

typedef struct {
  logic        write;
  logic [11:0] x;
  logic [11:0] y;
  logic [31:0] value;
} pixel_req_t;

typedef struct {
  logic [31:0] value;
  logic [1:0]  status;
} pixel_rsp_t;

class pixel_store_model;
  logic [14:0] stride;
  logic [1:0]  size_mode;
  logic [5:0]  depth;
  logic [1:0]  lay;
  logic        hbf;
  logic [2:0]  offset;
  logic [7:0]  image [STORE_BYTES];
  bit          written [STORE_BYTES];
  pixel_rsp_t  due_pixels [$];
  int unsigned errors;
  int unsigned results;

  function new();
    stride    = RST_ROW_STRIDE;
    size_mode = RST_MODE;
    depth     = RST_DEPTH;
    lay       = RST_LAYOUT;
    hbf       = 1'b0;
    offset    = 3'd0;
    errors    = 0;
    results   = 0;
  endfunction

  function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_ROW_STRIDE:      stride    = data[14:0];
      CFG_PIXEL_SIZE_MODE: size_mode = data[1:0];
      CFG_PIXEL_DEPTH:     depth     = data[5:0];
      CFG_LAYOUT:          lay       = data[1:0];
      CFG_HIGH_BYTE_FIRST: hbf       = data[0];
      CFG_BIT_OFFSET:      offset    = data[2:0];
      default: ;
    endcase
  endfunction

  function access_e locate(input logic [11:0] x, input logic [11:0] y,
                           output longint unsigned addr, output int unsigned nbytes,
                           output int unsigned bitpos, output bit masked);
    longint unsigned xo;
    addr   = 64'(y);
    nbytes = 0;
    bitpos = 0;
    masked = 1'b0;
    if (size_mode == MODE_1BPP && depth <= 6'd1) begin
      xo     = 64'(x);
      xo     = xo + 64'(offset);
      addr   = addr * 64'(stride) + (xo >> 3);
      bitpos = 32'(xo[2:0]);
      nbytes = 1;
      return ACC_BIT;
    end
    if (lay == LAYOUT_Z) begin
      case (size_mode)
        MODE_8BPP:  nbytes = 1;
        MODE_16BPP: nbytes = 2;
        MODE_32BPP: nbytes = 4;
        default:    nbytes = 0;
      endcase
      masked = 1'b1;
    end else if (lay == LAYOUT_RGBA && size_mode == MODE_32BPP) begin
      nbytes = 4;
    end
    if (nbytes == 0) return ACC_UNSUP;
    addr = addr * 64'(stride) + 64'(x) * 64'(nbytes);
    return ACC_BYTES;
  endfunction

  // True when the item would read a store byte that holds no written value.
  function bit touches_unwritten(input pixel_req_t r);
    longint unsigned addr;
    int unsigned     nbytes, bitpos;
    bit              masked;
    access_e         acc;
    acc = locate(r.x, r.y, addr, nbytes, bitpos, masked);
    if (acc == ACC_UNSUP || addr + nbytes > STORE_BYTES) return 1'b0;
    if (acc == ACC_BYTES && r.write == REQ_WRITE) return 1'b0;
    for (int i = 0; i < nbytes; i++) begin
      if (!written[addr + i]) return 1'b1;
    end
    return 1'b0;
  endfunction

  function void reach(output int unsigned xlim, output int unsigned ylim);
    longint unsigned addr;
    int unsigned     nbytes, bitpos;
    bit              masked;
    access_e         acc;
    acc = locate(12'd0, 12'd0, addr, nbytes, bitpos, masked);
    if (acc == ACC_BIT) begin
      xlim = 4095;
      ylim = (stride == 0) ? 4095 : (FILL_BYTES / 2) / stride;
    end else begin
      if (nbytes == 0) nbytes = 4;
      xlim = FILL_BYTES / nbytes - 1;
      ylim = (stride == 0) ? 4095 : (FILL_BYTES - 4) / stride;
    end
    if (ylim > 4095) ylim = 4095;
  endfunction

  function void note_access(input pixel_req_t r);
    longint unsigned addr;
    int unsigned     nbytes, bitpos, pos;
    bit              masked;
    access_e         acc;
    pixel_rsp_t      e;
    e.value  = '0;
    e.status = ST_OK;
    acc = locate(r.x, r.y, addr, nbytes, bitpos, masked);
    if (acc == ACC_UNSUP) begin
      e.status = ST_UNSUP;
    end else if (addr + nbytes > STORE_BYTES) begin
      e.status = ST_RANGE;
    end else if (acc == ACC_BIT) begin
      if (r.write == REQ_WRITE) image[addr][bitpos] = r.value[0];
      else e.value[0] = image[addr][bitpos];
    end else if (r.write == REQ_WRITE) begin
      for (int i = 0; i < nbytes; i++) begin
        pos = hbf ? nbytes - 1 - i : i;
        image[addr + pos]   = r.value[8*i +: 8];
        written[addr + pos] = 1'b1;
      end
    end else begin
      for (int i = 0; i < nbytes; i++) e.value[8*i +: 8] = image[addr + i];
      if (masked && depth < 6'd32) e.value = e.value & ~(32'hffffffff << depth);
    end
    due_pixels.push_back(e);
  endfunction

  function void check_response(input logic [31:0] value, input logic [1:0] status);
    pixel_rsp_t e;
    results++;
    if (due_pixels.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("result %0d: unexpected, read_value %h status %0d", results, value, status);
      return;
    end
    e = due_pixels.pop_front();
    if (value !== e.value || status !== e.status) begin
      errors++;
      if (errors <= 10)
        $display("result %0d: read_value exp %h got %h, status exp %0d got %0d",
                 results, e.value, value, e.status, status);
    end
  endfunction
endclass

module packed_pixel_access_unit_tb;
  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  bit                    calm;
  int unsigned           cycles = 0;

  ppau_req_if #(.COORD_BITS(12)) req_ch ();
  ppau_rsp_if                    rsp_ch ();

  pixel_store_model sb = new();

  packed_pixel_access_unit #(
    .STORE_BYTES(STORE_BYTES),
    .COORD_BITS (12)
  ) u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int unsigned hold;
    hold = 0;
    rsp_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rsp_ch.valid && rsp_ch.ready) sb.check_response(rsp_ch.read_value, rsp_ch.status);
      if (hold != 0) begin
        hold--;
        rsp_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        hold = $urandom_range(0, 2);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input pixel_req_t it);
    if (!calm && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= it.write;
    req_ch.x_pos       <= it.x;
    req_ch.y_pos       <= it.y;
    req_ch.pixel_value <= it.value;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    sb.note_access(it);
  endtask

  task automatic put(input logic w, input logic [11:0] x, input logic [11:0] y,
                     input logic [31:0] v);
    pixel_req_t it;
    it.write = w;
    it.x     = x;
    it.y     = y;
    it.value = v;
    send_item(it);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (sb.due_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic program_regs(input logic [14:0] stride, input logic [1:0] mode,
                              input logic [5:0] depth, input logic [1:0] lay,
                              input logic hbf, input logic [2:0] off);
    drain();
    reg_write(CFG_ROW_STRIDE, stride);
    reg_write(CFG_PIXEL_SIZE_MODE, CFG_DATA_W'(mode));
    reg_write(CFG_PIXEL_DEPTH, CFG_DATA_W'(depth));
    reg_write(CFG_LAYOUT, CFG_DATA_W'(lay));
    reg_write(CFG_HIGH_BYTE_FIRST, CFG_DATA_W'(hbf));
    reg_write(CFG_BIT_OFFSET, CFG_DATA_W'(off));
    cfg_we_i <= 1'b0;
  endtask

  function automatic pixel_req_t pick_item(input int unsigned xlim, input int unsigned ylim);
    pixel_req_t it;
    it.write = 1'($urandom_range(0, 1));
    it.value = $urandom;
    for (int t = 0; t < 16; t++) begin
      case ($urandom_range(0, 9))
        0: begin
          it.x = 12'($urandom);
          it.y = 12'($urandom);
        end
        1: begin
          it.x = $urandom_range(0, 1) ? 12'hfff : 12'h000;
          it.y = $urandom_range(0, 1) ? 12'hfff : 12'h000;
        end
        default: begin
          it.x = 12'($urandom_range(0, xlim));
          it.y = 12'($urandom_range(0, ylim));
        end
      endcase
      if (!sb.touches_unwritten(it)) return it;
    end
    it.write = REQ_WRITE;
    if (sb.touches_unwritten(it)) begin
      it.x = '0;
      it.y = '0;
    end
    return it;
  endfunction

  task automatic directed_part();
    // reset register values
    put(REQ_WRITE, 12'd0,    12'd0,    32'hffffffff);
    put(REQ_READ,  12'd0,    12'd0,    32'h0);
    put(REQ_WRITE, 12'd4095, 12'd4095, 32'h00000000);
    put(REQ_READ,  12'd4095, 12'd4095, 32'h0);
    // 8 bpp, zero depth, widest stride, last store byte and just past it
    program_regs(15'd32767, MODE_8BPP, 6'd0, LAYOUT_Z, 1'b1, 3'd7);
    put(REQ_READ,  12'd0,    12'd0,    32'h0);
    put(REQ_WRITE, 12'd1,    12'd1,    32'h0000005a);
    put(REQ_WRITE, 12'd1,    12'd2,    32'hffffff3c);
    put(REQ_WRITE, 12'd2,    12'd2,    32'h12345678);
    put(REQ_READ,  12'd4095, 12'd4095, 32'h0);
    // 16 bpp, high byte first, depth above 32
    program_regs(15'd16384, MODE_16BPP, 6'd63, LAYOUT_Z, 1'b1, 3'd0);
    put(REQ_READ,  12'd0,    12'd4,    32'h0);
    put(REQ_WRITE, 12'd0,    12'd0,    32'h12345678);
    put(REQ_READ,  12'd0,    12'd0,    32'h0);
    put(REQ_WRITE, 12'd4095, 12'd3,    32'hdeadbeef);
    put(REQ_READ,  12'd4095, 12'd3,    32'h0);
    // packed RGBA reads ignore the depth
    program_regs(15'd1, MODE_32BPP, 6'd1, LAYOUT_RGBA, 1'b0, 3'd0);
    put(REQ_READ,  12'd0,    12'd0,    32'h0);
    put(REQ_WRITE, 12'd0,    12'd1,    32'h80000001);
    put(REQ_READ,  12'd0,    12'd1,    32'h0);
    program_regs(15'd4, MODE_8BPP, 6'd8, LAYOUT_RGBA, 1'b0, 3'd0);
    put(REQ_WRITE, 12'd0,    12'd0,    32'hffffffff);
    put(REQ_READ,  12'd0,    12'd0,    32'h0);
    // bit mode with the largest bit offset, crossing into the next byte
    program_regs(15'd4, MODE_1BPP, 6'd1, LAYOUT_PLANE, 1'b0, 3'd7);
    put(REQ_WRITE, 12'd0,    12'd0,    32'h00000001);
    put(REQ_READ,  12'd0,    12'd0,    32'h0);
    put(REQ_WRITE, 12'd1,    12'd0,    32'hfffffffe);
    put(REQ_READ,  12'd1,    12'd0,    32'h0);
    program_regs(15'd32767, MODE_1BPP, 6'd0, LAYOUT_SPARE, 1'b1, 3'd0);
    put(REQ_READ,  12'd4095, 12'd2,    32'h0);
    put(REQ_WRITE, 12'd0,    12'd0,    32'h0);
    program_regs(15'd4, MODE_1BPP, 6'd2, LAYOUT_Z, 1'b0, 3'd0);
    put(REQ_READ,  12'd0,    12'd0,    32'h0);
    program_regs(15'd0, MODE_32BPP, 6'd32, LAYOUT_SPARE, 1'b0, 3'd0);
    put(REQ_WRITE, 12'd4095, 12'd4095, 32'hffffffff);
  endtask

  task automatic random_phase(input int p);
    logic [14:0] stride;
    logic [1:0]  mode;
    logic [5:0]  depth;
    logic [1:0]  lay;
    int unsigned xlim, ylim, count;
    mode = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 5))
      0:       depth = 6'd0;
      1:       depth = 6'd1;
      2:       depth = 6'd32;
      3:       depth = 6'd63;
      default: depth = 6'($urandom_range(0, 63));
    endcase
    if (mode == MODE_1BPP && $urandom_range(0, 3) != 0) depth = 6'($urandom_range(0, 1));
    if ($urandom_range(0, 9) < 6) lay = LAYOUT_Z;
    else lay = 2'($urandom_range(0, 3));
    if (mode == MODE_32BPP && $urandom_range(0, 2) == 0) lay = LAYOUT_RGBA;
    case ($urandom_range(0, 9))
      0:       stride = 15'd1;
      1:       stride = 15'd16384;
      2:       stride = 15'd32767;
      default: stride = 15'($urandom_range(1, 300));
    endcase
    if (p == 0) stride = 15'd0;
    program_regs(stride, mode, depth, lay, 1'($urandom_range(0, 1)),
                 3'($urandom_range(0, 7)));
    sb.reach(xlim, ylim);
    count = calm ? 150 : 55;
    repeat (count) send_item(pick_item(xlim, ylim));
  endtask

  initial begin
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= CFG_ROW_STRIDE;
    cfg_data_i         <= '0;
    req_ch.valid       <= 1'b0;
    req_ch.req_type    <= REQ_READ;
    req_ch.x_pos       <= '0;
    req_ch.y_pos       <= '0;
    req_ch.pixel_value <= '0;
    calm = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_part();
    // give every byte of the low region a known value
    program_regs(15'd4, MODE_32BPP, 6'd32, LAYOUT_Z, 1'b0, 3'd0);
    for (int i = 0; i < FILL_BYTES / 4; i++) put(REQ_WRITE, 12'd0, 12'(i), $urandom);
    for (int p = 0; p < 13; p++) begin
      if (p == 12) calm = 1'b1;
      random_phase(p);
    end
    drain();
    if (sb.errors == 0 && sb.due_pixels.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
